[rtl/core/line_pixel_generator_macros.svh]
// assertion macros for the line pixel generator checker
// expects clk and arst_n in the scope where a macro is used
`ifndef LINE_PIXEL_GENERATOR_MACROS_SVH
`define LINE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define LPG_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line pixel generator check failed");

// next-cycle implication
`define LPG_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line pixel generator check failed");

`endif

[rtl/core/lpg_pkg.sv]
// shared types, constants and helpers for the line pixel generator
// no dependencies
package lpg_pkg;

	localparam int unsigned COORD_BITS_DEF = 6;
	localparam int unsigned FIELD_BITS     = 6;

	typedef struct packed {
		logic [FIELD_BITS-1:0] start_x;
		logic [FIELD_BITS-1:0] start_y;
		logic [FIELD_BITS-1:0] end_x;
		logic [FIELD_BITS-1:0] end_y;
		logic [23:0]           color_rgb;
	} line_cmd_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] pixel_x;
		logic [FIELD_BITS-1:0] pixel_y;
		logic [15:0]           color_565;
		logic                  last_pixel;
	} pixel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} dp_status_t;

	function automatic logic [15:0] to_565(input logic [23:0] c);
		return {c[23:19], c[15:10], c[7:3]};
	endfunction

endpackage

[rtl/core/lpg_ctrl.sv]
// controller state machine for the line pixel generator
// depends on lpg_pkg
module lpg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  lpg_pkg::dp_status_t status,
	output lpg_pkg::dp_cmd_t    ctl
);

	lpg_pkg::state_t state_q;
	lpg_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		ctl       = '0;
		case (state_q)
			lpg_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = lpg_pkg::ST_SETUP;
				end
			end
			lpg_pkg::ST_SETUP: begin
				ctl.setup = 1'b1;
				state_d   = lpg_pkg::ST_WALK;
			end
			lpg_pkg::ST_WALK: begin
				ctl.step = status.out_free;
				if (status.out_free && status.last) begin
					state_d = lpg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/lpg_datapath.sv]
// datapath for the line pixel generator: command latch, setup, bresenham step, output register
// depends on lpg_pkg
module lpg_datapath #(
	parameter int unsigned COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lpg_pkg::line_cmd_t  cmd,
	input  lpg_pkg::dp_cmd_t    ctl,
	output lpg_pkg::dp_status_t status,
	output lpg_pkg::pixel_t     pix,
	output logic                pix_valid,
	input  logic                pix_ready
);

	localparam int unsigned ERR_BITS = COORD_BITS + 2;

	typedef logic [COORD_BITS-1:0] coord_t;

	coord_t x0_q, y0_q, x1_q, y1_q;
	logic [15:0] color_q;

	coord_t major_q, minor_q, end_q, dmaj_q, dmin_q;
	logic down_q;
	logic swap_q;
	logic signed [ERR_BITS-1:0] err_q;

	lpg_pkg::pixel_t pix_q;
	logic pix_valid_q;

	coord_t dx, dy;
	logic steep;
	coord_t a0, b0, a1, b1;
	logic flip;
	coord_t sa0, sb0, sa1, sb1;
	coord_t dmaj, dmin;

	logic signed [ERR_BITS-1:0] err_sub;
	logic signed [ERR_BITS-1:0] err_next;
	logic err_neg;
	coord_t minor_next;
	coord_t px, py;
	logic last;

	// setup
	always_comb begin
		dx    = (x0_q > x1_q) ? x0_q - x1_q : x1_q - x0_q;
		dy    = (y0_q > y1_q) ? y0_q - y1_q : y1_q - y0_q;
		steep = dy > dx;
		a0    = steep ? y0_q : x0_q;
		b0    = steep ? x0_q : y0_q;
		a1    = steep ? y1_q : x1_q;
		b1    = steep ? x1_q : y1_q;
		flip  = a0 > a1;
		sa0   = flip ? a1 : a0;
		sb0   = flip ? b1 : b0;
		sa1   = flip ? a0 : a1;
		sb1   = flip ? b0 : b1;
		dmaj  = sa1 - sa0;
		dmin  = (sb0 > sb1) ? sb0 - sb1 : sb1 - sb0;
	end

	// bresenham step
	always_comb begin
		err_sub  = err_q - $signed({2'b00, dmin_q});
		err_neg  = err_sub[ERR_BITS-1];
		err_next = err_neg ? err_sub + $signed({2'b00, dmaj_q}) : err_sub;
		if (!err_neg) begin
			minor_next = minor_q;
		end else if (down_q) begin
			minor_next = minor_q - coord_t'(1);
		end else begin
			minor_next = minor_q + coord_t'(1);
		end
		px   = swap_q ? minor_q : major_q;
		py   = swap_q ? major_q : minor_q;
		last = major_q >= end_q;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x0_q    <= cmd.start_x[COORD_BITS-1:0];
			y0_q    <= cmd.start_y[COORD_BITS-1:0];
			x1_q    <= cmd.end_x[COORD_BITS-1:0];
			y1_q    <= cmd.end_y[COORD_BITS-1:0];
			color_q <= lpg_pkg::to_565(cmd.color_rgb);
		end
		if (ctl.setup) begin
			major_q <= sa0;
			minor_q <= sb0;
			end_q   <= sa1;
			dmaj_q  <= dmaj;
			dmin_q  <= dmin;
			down_q  <= !(sb0 < sb1);
			swap_q  <= steep;
			err_q   <= $signed({2'b00, (dmaj >> 1)});
		end else if (ctl.step) begin
			minor_q <= minor_next;
			err_q   <= err_next;
			if (!last) begin
				major_q <= major_q + coord_t'(1);
			end
		end
		if (ctl.step) begin
			pix_q.pixel_x    <= lpg_pkg::FIELD_BITS'(px);
			pix_q.pixel_y    <= lpg_pkg::FIELD_BITS'(py);
			pix_q.color_565  <= color_q;
			pix_q.last_pixel <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (ctl.step) begin
			pix_valid_q <= 1'b1;
		end else if (pix_ready) begin
			pix_valid_q <= 1'b0;
		end
	end

	assign status.last     = last;
	assign status.out_free = !pix_valid_q || pix_ready;
	assign pix             = pix_q;
	assign pix_valid       = pix_valid_q;

endmodule

[rtl/core/line_pixel_generator.sv]
// line pixel generator top level: bresenham walk of one line command into pixel beats
// the first pixel beat passes the command latch, setup registers and output register
// throughput: one pixel per cycle while pix_ready keeps the output register free,
// set by the single step unit walking the major axis one pixel a cycle
// reset: arst_n clears the controller to idle and empties the output register
module line_pixel_generator #(
	parameter int unsigned COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  lpg_pkg::line_cmd_t cmd,
	output logic               pix_valid,
	input  logic               pix_ready,
	output lpg_pkg::pixel_t    pix
);

	lpg_pkg::dp_cmd_t    ctl;
	lpg_pkg::dp_status_t status;

	lpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.status    (status),
		.ctl       (ctl)
	);

	lpg_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.status    (status),
		.pix       (pix),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready)
	);

endmodule

[rtl/core/lpg_checker.sv]
// port-level checker for the line pixel generator, bound to the top level
// depends on lpg_pkg and line_pixel_generator_macros.svh
`include "line_pixel_generator_macros.svh"

module lpg_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input lpg_pkg::line_cmd_t cmd,
	input logic               pix_valid,
	input logic               pix_ready,
	input lpg_pkg::pixel_t    pix
);

	// stalled pixel beat holds
	`LPG_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix))

	// busy right after a command beat
	`LPG_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready)

	// a beat waiting while idle is the end of a line
	`LPG_ASSERT_IMPL(a_idle_only_last, cmd_ready && pix_valid, pix.last_pixel)

	// mid-line beat is followed at once by the next one
	`LPG_ASSERT_NEXT(a_walk_continues, pix_valid && pix_ready && !pix.last_pixel, pix_valid)

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (.*);
